// ----- hw/rtl/int8_broadcast_elementwise_mult_core_defines.svh -----
// assertion macros used by the rtl core
`ifndef INT8_BROADCAST_ELEMENTWISE_MULT_CORE_DEFINES_SVH
`define INT8_BROADCAST_ELEMENTWISE_MULT_CORE_DEFINES_SVH

// property checked every cycle out of reset
`define IBEM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define IBEM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ibem_pkg.sv -----
package ibem_pkg;

  localparam int unsigned MAX_CHANNELS_DEF = 256;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_OFFSET   = 3'd0,
    REG_SECOND_OFFSET  = 3'd1,
    REG_RESULT_OFFSET  = 3'd2,
    REG_CLAMP_LOW      = 3'd3,
    REG_CLAMP_HIGH     = 3'd4,
    REG_SCALE_MANTISSA = 3'd5,
    REG_SCALE_SHIFT    = 3'd6,
    REG_CHANNELS_USED  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [8:0] first_offset;
    logic signed [8:0] second_offset;
    logic signed [7:0] result_offset;
    logic signed [7:0] clamp_low;
    logic signed [7:0] clamp_high;
    logic [30:0]       scale_mantissa;
    logic [5:0]        scale_shift;
    logic [8:0]        channels_used;
  } cfg_t;

  // control that travels with each element down the pipeline
  typedef struct packed {
    logic valid;
    logic pixel_last;
    logic frame_last;
  } ctl_t;

endpackage

// ----- hw/rtl/ibem_vec_mem.sv -----
module ibem_vec_mem #(
  parameter int unsigned Depth = ibem_pkg::MAX_CHANNELS_DEF,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/ibem_scale.sv -----
module ibem_scale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  ibem_pkg::cfg_t    cfg_i,
  input  ibem_pkg::ctl_t    ctl_i,
  input  logic signed [9:0] a_i,
  input  logic [7:0]        entry_i,
  output ibem_pkg::ctl_t    ctl_o,
  output logic [7:0]        product_o
);
  import ibem_pkg::*;

  // offset entry, multiply, take magnitude
  ctl_t              s2_q;
  logic [17:0]       mag_q;
  logic              neg2_q;
  logic signed [9:0] b;
  logic signed [19:0] p;
  logic [19:0]       pabs;

  // mantissa product
  ctl_t              s3_q;
  logic [48:0]       prod_q;
  logic              neg3_q;

  // shift, sign, offset, clamp
  ctl_t               out_q;
  logic [7:0]         product_q;
  logic [48:0]        scaled;
  logic [8:0]         sat;
  logic signed [10:0] sv;
  logic signed [10:0] r;
  logic signed [10:0] lo;
  logic signed [10:0] hi;

  always_comb begin
    b    = 10'(signed'(entry_i)) + 10'(cfg_i.second_offset);
    p    = 20'(a_i) * 20'(b);
    pabs = p[19] ? 20'(-p) : 20'(p);
  end

  always_comb begin
    scaled = prod_q >> cfg_i.scale_shift;
    sat    = (|scaled[48:9]) ? 9'h1FF : scaled[8:0];
    sv     = signed'({2'b00, sat});
    if (neg3_q) begin
      sv = -sv;
    end
    lo = 11'(cfg_i.clamp_low);
    hi = 11'(cfg_i.clamp_high);
    r  = sv + 11'(cfg_i.result_offset);
    if (r < lo) begin
      r = lo;
    end
    if (r > hi) begin
      r = hi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q  <= '0;
      s3_q  <= '0;
      out_q <= '0;
    end else if (en_i) begin
      s2_q  <= ctl_i;
      s3_q  <= s2_q;
      out_q <= s3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q     <= pabs[17:0];
      neg2_q    <= p[19];
      prod_q    <= 49'(mag_q) * 49'(cfg_i.scale_mantissa);
      neg3_q    <= neg2_q;
      product_q <= r[7:0];
    end
  end

  assign ctl_o     = out_q;
  assign product_o = product_q;

endmodule

// ----- hw/rtl/int8_broadcast_elementwise_mult_core.sv -----
// int8 tensor times per-channel vector, quantized
// input channel (in_valid_i / in_stall_o): kind_i low loads value_i into
// vector entry entry_index_i and gives no result; kind_i high is one tensor
// element in channel order, multiplied with the entry the channel counter picks
// output channel (out_valid_o / out_stall_i): one clamped int8 result per
// element with pixel_last_o and frame_last_o
// a taken element is registered in stage s1, then in the three scale stages
// throughput: one request per cycle unless stalled, set by the single read
// port of the vector memory feeding a three stage multiply and scale pipeline
// config port: cfg_we_i writes register cfg_index_i at once; write only
// while the block is empty; writing channels_used restarts the counter
// reset: config returns to defaults, counter to channel 0, pipeline empties;
// vector entries hold no value until loaded
// a stalled output freezes the whole pipeline and stalls the input
`include "int8_broadcast_elementwise_mult_core_defines.svh"

module int8_broadcast_elementwise_mult_core #(
  parameter int unsigned MaxChannels = ibem_pkg::MAX_CHANNELS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             kind_i,
  input  logic signed [7:0]                value_i,
  input  logic [7:0]                       entry_index_i,
  input  logic                             frame_end_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [7:0]                product_out_o,
  output logic                             pixel_last_o,
  output logic                             frame_last_o,
  input  logic                             cfg_we_i,
  input  logic [ibem_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ibem_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import ibem_pkg::*;

  localparam int unsigned AddrW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int unsigned EffW  = ($clog2(MaxChannels + 1) > 9) ?
                                  $clog2(MaxChannels + 1) : 9;

  cfg_t cfg_q, cfg_d;

  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [AddrW-1:0] ch;
  logic [EffW-1:0]  nch;
  logic [EffW-1:0]  cu_w;
  logic [EffW-1:0]  idx_w;
  logic             plast;
  logic             en;
  logic             accept;
  logic             load_we;

  ctl_t              s1_q;
  ctl_t              s1_d;
  logic signed [9:0] a_q;
  logic [7:0]        entry;
  ctl_t              res;
  logic [7:0]        product;

  assign en         = !res.valid || !out_stall_i;
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FIRST_OFFSET:   cfg_d.first_offset   = cfg_wdata_i[8:0];
        REG_SECOND_OFFSET:  cfg_d.second_offset  = cfg_wdata_i[8:0];
        REG_RESULT_OFFSET:  cfg_d.result_offset  = cfg_wdata_i[7:0];
        REG_CLAMP_LOW:      cfg_d.clamp_low      = cfg_wdata_i[7:0];
        REG_CLAMP_HIGH:     cfg_d.clamp_high     = cfg_wdata_i[7:0];
        REG_SCALE_MANTISSA: cfg_d.scale_mantissa = cfg_wdata_i[30:0];
        REG_SCALE_SHIFT:    cfg_d.scale_shift    = cfg_wdata_i[5:0];
        REG_CHANNELS_USED:  cfg_d.channels_used  = cfg_wdata_i[8:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  // effective channel count
  always_comb begin
    cu_w = EffW'(cfg_q.channels_used);
    if (cu_w == '0) begin
      nch = EffW'(1);
    end else if (cu_w > EffW'(MaxChannels)) begin
      nch = EffW'(MaxChannels);
    end else begin
      nch = cu_w;
    end
  end

  always_comb begin
    ch    = (EffW'(cnt_q) >= nch) ? '0 : cnt_q;
    plast = (EffW'(ch) + EffW'(1)) >= nch;
    cnt_d = cnt_q;
    if (cfg_we_i && (cfg_reg_e'(cfg_index_i) == REG_CHANNELS_USED)) begin
      cnt_d = '0;
    end else if (accept && kind_i) begin
      cnt_d = (frame_end_i || plast) ? '0 : ch + AddrW'(1);
    end
  end

  always_comb begin
    s1_d.valid      = accept && kind_i;
    s1_d.pixel_last = plast;
    s1_d.frame_last = frame_end_i;
  end

  assign idx_w   = EffW'(entry_index_i);
  assign load_we = accept && !kind_i && (idx_w < EffW'(MaxChannels));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_offset   <= 9'sd0;
      cfg_q.second_offset  <= 9'sd0;
      cfg_q.result_offset  <= 8'sd0;
      cfg_q.clamp_low      <= -8'sd128;
      cfg_q.clamp_high     <= 8'sd127;
      cfg_q.scale_mantissa <= 31'd1073741824;
      cfg_q.scale_shift    <= 6'd31;
      cfg_q.channels_used  <= 9'd1;
      cnt_q                <= '0;
      s1_q                 <= '0;
    end else begin
      cfg_q <= cfg_d;
      cnt_q <= cnt_d;
      if (en) begin
        s1_q <= s1_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= 10'(value_i) + 10'(cfg_q.first_offset);
    end
  end

  ibem_vec_mem #(
    .Depth (MaxChannels),
    .AddrW (AddrW)
  ) u_vec_mem (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (idx_w[AddrW-1:0]),
    .wdata_i (value_i),
    .re_i    (s1_d.valid),
    .raddr_i (ch),
    .rdata_o (entry)
  );

  ibem_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .cfg_i     (cfg_q),
    .ctl_i     (s1_q),
    .a_i       (a_q),
    .entry_i   (entry),
    .ctl_o     (res),
    .product_o (product)
  );

  assign out_valid_o   = res.valid;
  assign product_out_o = product;
  assign pixel_last_o  = res.pixel_last;
  assign frame_last_o  = res.frame_last;

  `IBEM_ASSERT(cnt_in_range_a, clk_i, rst_ni, EffW'(cnt_q) < nch, "channel counter out of range")
  `IBEM_ASSERT_NEXT(elem_enters_a, clk_i, rst_ni, accept && kind_i, s1_q.valid, "element lost")
  `IBEM_ASSERT_NEXT(load_silent_a, clk_i, rst_ni, accept && !kind_i, !s1_q.valid, "load made a result")
  `IBEM_ASSERT_NEXT(frame_restart_a, clk_i, rst_ni, accept && kind_i && frame_end_i, cnt_q == '0, "counter not restarted")

endmodule
